// File: src/rsttab_pkg.sv
// Shared constants, command codes and control types for the record slot table.
`timescale 1ns / 1ps
package rsttab_pkg;

  localparam int CmdW  = 3;
  localparam int KeyW  = 32;
  localparam int PayW  = 64;
  localparam int CntW  = 7;
  localparam int StatW = 2;

  localparam int SlotsDef       = 64;
  localparam int PayloadBitsDef = 64;

  localparam logic [CmdW-1:0] CMD_ADD     = 3'd0;
  localparam logic [CmdW-1:0] CMD_GET     = 3'd1;
  localparam logic [CmdW-1:0] CMD_UPDATE  = 3'd2;
  localparam logic [CmdW-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_COMPACT = 3'd4;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatW-1:0] ST_MISSING = 2'd2;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic [CmdW-1:0] cmd;    // command under way, steers the token action
    logic            add;    // write the request into the slot at the fill level
    logic            mark;   // tag slots past the fill level as dead
    logic            sort;   // one odd-even exchange phase
    logic            phase;  // parity of the pairs that exchange
  } cell_ctl_t;

endpackage

// File: src/rsttab_ifs.sv
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
interface rsttab_in_if import rsttab_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [KeyW-1:0] record_key;
  logic [PayW-1:0] record_payload;

  modport source (output valid, cmd, record_key, record_payload, input ready);
  modport sink   (input valid, cmd, record_key, record_payload, output ready);
endinterface

interface rsttab_out_if import rsttab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic             hit;
  logic [PayW-1:0]  payload_out;
  logic [CntW-1:0]  entry_count;
  logic [CntW-1:0]  free_count;
  logic             is_full;
  logic             is_empty;
  logic             is_dirty;

  modport source (output valid, status, hit, payload_out, entry_count, free_count,
                  is_full, is_empty, is_dirty, input ready);
  modport sink   (input valid, status, hit, payload_out, entry_count, free_count,
                  is_full, is_empty, is_dirty, output ready);
endinterface

// File: src/rsttab_cell.sv
// One slot of the chain: record storage, token stage and odd-even exchange.
`timescale 1ns / 1ps
module rsttab_cell import rsttab_pkg::*; #(
  parameter int SLOTS        = SlotsDef,
  parameter int PAYLOAD_BITS = PayloadBitsDef,
  parameter int IDX          = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cell_ctl_t                            ctl,
  input  logic [$clog2(SLOTS+1)-1:0]           used,
  input  logic [KeyW-1:0]                      req_key,
  input  logic [PAYLOAD_BITS-1:0]              req_data,
  // neighbor records
  input  logic [KeyW-1:0]                      l_key,
  input  logic [PAYLOAD_BITS-1:0]              l_data,
  input  logic                                 l_dead,
  input  logic [KeyW-1:0]                      r_key,
  input  logic [PAYLOAD_BITS-1:0]              r_data,
  input  logic                                 r_dead,
  output logic [KeyW-1:0]                      key_r,
  output logic [PAYLOAD_BITS-1:0]              data_r,
  output logic                                 dead_r,
  // search token
  input  logic                                 tok_vld_in,
  input  logic                                 tok_hit_in,
  input  logic [PAYLOAD_BITS-1:0]              tok_data_in,
  output logic                                 tok_vld_r,
  output logic                                 tok_hit_r,
  output logic [PAYLOAD_BITS-1:0]              tok_data_r
);

  localparam int CW = $clog2(SLOTS+1);
  localparam logic [CW-1:0] IDX_V = CW'(IDX);
  localparam logic          PAR   = 1'(IDX % 2);

  logic [KeyW-1:0]         key_nxt;
  logic [PAYLOAD_BITS-1:0] data_nxt;
  logic                    dead_nxt;
  logic                    tok_hit_nxt;
  logic [PAYLOAD_BITS-1:0] tok_data_nxt;
  logic                    occupied;
  logic                    match;
  logic                    swap_r;
  logic                    swap_l;

  assign occupied = (IDX_V < used);
  assign match    = tok_vld_in && !tok_hit_in && occupied && !dead_r && (key_r == req_key);
  // Move a tombstone right past a live record; equal pairs stay put so order holds.
  assign swap_r   = (ctl.phase == PAR) && dead_r && !r_dead;
  assign swap_l   = (ctl.phase != PAR) && l_dead && !dead_r;

  always_comb begin
    key_nxt      = key_r;
    data_nxt     = data_r;
    dead_nxt     = dead_r;
    tok_hit_nxt  = tok_hit_in | match;
    tok_data_nxt = tok_data_in;
    if (ctl.sort) begin
      if (swap_r) begin
        key_nxt  = r_key;
        data_nxt = r_data;
        dead_nxt = r_dead;
      end else if (swap_l) begin
        key_nxt  = l_key;
        data_nxt = l_data;
        dead_nxt = l_dead;
      end
    end else if (ctl.mark) begin
      if (!occupied) begin
        dead_nxt = 1'b1;
      end
    end else if (ctl.add && (IDX_V == used)) begin
      key_nxt  = req_key;
      data_nxt = req_data;
      dead_nxt = 1'b0;
    end else if (match) begin
      case (ctl.cmd)
        CMD_GET:    tok_data_nxt = data_r;
        CMD_UPDATE: data_nxt = req_data;
        CMD_DELETE: dead_nxt = 1'b1;
        default:    tok_data_nxt = tok_data_in;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    dead_r     <= dead_nxt;
    tok_hit_r  <= tok_hit_nxt;
    tok_data_r <= tok_data_nxt;
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

endmodule

// File: src/record_slot_table_with_tombstones_top.sv
// Top level: command sequencer, result register and the chain of slot cells.
`timescale 1ns / 1ps
// Record slot table with tombstones.
// Requests arrive as beats on in_chan (cmd, record_key, record_payload); each
// request gives exactly one result beat on out_chan with status, hit, payload
// and the occupancy and dirty flag after the command.
// Storage is a chain of SLOTS cells, one record per cell. A lookup (get,
// update, delete) launches a token into cell 0 that moves one cell per cycle;
// the first live cell with a matching key claims it, and the result is taken
// once the token leaves the last cell. Compact marks the unused tail dead
// and then runs SLOTS odd-even exchange phases across neighbor cells, pushing
// tombstones to the end while live records keep their order. One request is
// in flight at a time.
// in_chan.ready is high whenever the sequencer is idle, also while a result
// beat still waits in the output register; if the receiver stalls, the next
// result holds in the sequencer until the output register frees up.
// Reset empties the table and clears the dirty flag; slot contents are not
// cleared, slots past the fill level are never read.
module record_slot_table_with_tombstones_top import rsttab_pkg::*; #(
  parameter int SLOTS        = SlotsDef,
  parameter int PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  rsttab_in_if.sink    in_chan,
  rsttab_out_if.source out_chan
);

  localparam int CW = $clog2(SLOTS+1);
  localparam logic [CW-1:0] SLOTS_V = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_PH = CW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SORT   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CmdW-1:0]         cmd_r, cmd_nxt;
  logic [KeyW-1:0]         key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] data_r, data_nxt;
  logic [CW-1:0]           used_r, used_nxt;
  logic [CW-1:0]           dead_cnt_r, dead_cnt_nxt;
  logic                    dirty_r, dirty_nxt;
  logic [CW-1:0]           phase_r, phase_nxt;
  logic [StatW-1:0]        res_status_r, res_status_nxt;
  logic                    res_hit_r, res_hit_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [StatW-1:0]        out_status_r;
  logic                    out_hit_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [CntW-1:0]         out_entry_r;
  logic [CntW-1:0]         out_free_r;
  logic                    out_full_r;
  logic                    out_empty_r;
  logic                    out_dirty_r;
  logic                    load_out;
  logic                    launch;
  cell_ctl_t               ctl;

  logic [KeyW-1:0]         c_key  [SLOTS];
  logic [PAYLOAD_BITS-1:0] c_data [SLOTS];
  logic                    c_dead [SLOTS];
  logic                    t_vld  [SLOTS+1];
  logic                    t_hit  [SLOTS+1];
  logic [PAYLOAD_BITS-1:0] t_data [SLOTS+1];

  assign in_chan.ready = (state_r == S_IDLE);
  assign load_out      = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);
  assign launch        = (state_r == S_EXEC) &&
                         ((cmd_r == CMD_GET) || (cmd_r == CMD_UPDATE) || (cmd_r == CMD_DELETE));

  always_comb begin
    ctl.cmd   = cmd_r;
    ctl.add   = (state_r == S_EXEC) && (cmd_r == CMD_ADD) && (used_r != SLOTS_V);
    ctl.mark  = (state_r == S_EXEC) && (cmd_r == CMD_COMPACT);
    ctl.sort  = (state_r == S_SORT);
    ctl.phase = phase_r[0];
  end

  // Token enters at cell 0 empty-handed.
  assign t_vld[0]  = launch;
  assign t_hit[0]  = 1'b0;
  assign t_data[0] = '0;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    used_nxt       = used_r;
    dead_cnt_nxt   = dead_cnt_r;
    dirty_nxt      = dirty_r;
    phase_nxt      = phase_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r;
    if (out_chan.valid && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt        = in_chan.cmd;
          key_nxt        = in_chan.record_key;
          data_nxt       = in_chan.record_payload[PAYLOAD_BITS-1:0];
          res_status_nxt = ST_OK;
          res_hit_nxt    = 1'b0;
          res_pay_nxt    = '0;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_ADD: begin
            if (used_r == SLOTS_V) begin
              res_status_nxt = ST_FULL;
            end else begin
              used_nxt  = used_r + 1'b1;
              dirty_nxt = 1'b1;
            end
            state_nxt = S_FIN;
          end
          CMD_GET, CMD_UPDATE, CMD_DELETE: state_nxt = S_SEARCH;
          CMD_COMPACT: begin
            phase_nxt = '0;
            state_nxt = S_SORT;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_SEARCH: begin
        // Wait for the token to leave the last cell.
        if (t_vld[SLOTS]) begin
          if (t_hit[SLOTS]) begin
            res_hit_nxt = 1'b1;
            res_pay_nxt = t_data[SLOTS];
            if (cmd_r != CMD_GET) begin
              dirty_nxt = 1'b1;
            end
            if (cmd_r == CMD_DELETE) begin
              dead_cnt_nxt = dead_cnt_r + 1'b1;
            end
          end else begin
            res_status_nxt = ST_MISSING;
          end
          state_nxt = S_FIN;
        end
      end
      S_SORT: begin
        phase_nxt = phase_r + 1'b1;
        if (phase_r == LAST_PH) begin
          used_nxt     = used_r - dead_cnt_r;
          dead_cnt_nxt = '0;
          dirty_nxt    = 1'b0;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    data_r       <= data_nxt;
    phase_r      <= phase_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_pay_r    <= res_pay_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
      out_pay_r    <= res_pay_r;
      out_entry_r  <= CntW'(used_r);
      out_free_r   <= CntW'(SLOTS_V - used_r);
      out_full_r   <= (used_r == SLOTS_V);
      out_empty_r  <= (used_r == '0);
      out_dirty_r  <= dirty_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      dead_cnt_r  <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      dead_cnt_r  <= dead_cnt_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.payload_out = PayW'(out_pay_r);
  assign out_chan.entry_count = out_entry_r;
  assign out_chan.free_count  = out_free_r;
  assign out_chan.is_full     = out_full_r;
  assign out_chan.is_empty    = out_empty_r;
  assign out_chan.is_dirty    = out_dirty_r;

  // Chain of slot cells; the ends see a phantom neighbor that never exchanges.
  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    logic [KeyW-1:0]         lk, rk;
    logic [PAYLOAD_BITS-1:0] ld, rd;
    logic                    ldd, rdd;

    if (j == 0) begin : g_lend
      assign lk  = '0;
      assign ld  = '0;
      assign ldd = 1'b0;
    end else begin : g_lnb
      assign lk  = c_key[j-1];
      assign ld  = c_data[j-1];
      assign ldd = c_dead[j-1];
    end

    if (j == SLOTS - 1) begin : g_rend
      assign rk  = '0;
      assign rd  = '0;
      assign rdd = 1'b1;
    end else begin : g_rnb
      assign rk  = c_key[j+1];
      assign rd  = c_data[j+1];
      assign rdd = c_dead[j+1];
    end

    rsttab_cell #(
      .SLOTS        (SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX          (j)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .used        (used_r),
      .req_key     (key_r),
      .req_data    (data_r),
      .l_key       (lk),
      .l_data      (ld),
      .l_dead      (ldd),
      .r_key       (rk),
      .r_data      (rd),
      .r_dead      (rdd),
      .key_r       (c_key[j]),
      .data_r      (c_data[j]),
      .dead_r      (c_dead[j]),
      .tok_vld_in  (t_vld[j]),
      .tok_hit_in  (t_hit[j]),
      .tok_data_in (t_data[j]),
      .tok_vld_r   (t_vld[j+1]),
      .tok_hit_r   (t_hit[j+1]),
      .tok_data_r  (t_data[j+1])
    );
  end

endmodule

// File: verif/tb_record_slot_table_with_tombstones_top.sv
// Self-checking testbench for the record slot table: directed rows, then random traffic.
`timescale 1ns / 1ps
module tb_record_slot_table_with_tombstones_top import rsttab_pkg::*; ();

  // Command codes outside the defined set; the block answers them with no change.
  localparam logic [CmdW-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int RAND_PER_PHASE = 282;
  localparam int POOL_SIZE      = 12;
  // The 1151 request beats stay far below this limit even with heavy stalls in
  // the slowest phase.
  localparam int CYCLE_LIMIT    = 600000;

  // Traffic shapes used by the random part.
  typedef enum logic [1:0] {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  // One result beat, field for field.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic             hit;
    logic [PayW-1:0]  payload;
    logic [CntW-1:0]  entries;
    logic [CntW-1:0]  free;
    logic             full;
    logic             empty;
    logic             dirty;
  } table_reply_t;

  // One row of the directed stimulus; typed rows carry a hand-written reply.
  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    bit              typed;
    table_reply_t    reply;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rsttab_in_if  in_chan ();
  rsttab_out_if out_chan ();

  record_slot_table_with_tombstones_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow of the table: slots in insertion order, fill level and dirty flag.
  logic [KeyW-1:0] shadow_key  [SlotsDef];
  logic [PayW-1:0] shadow_pay  [SlotsDef];
  logic            shadow_dead [SlotsDef];
  int              shadow_fill;
  logic            shadow_dirty;

  table_reply_t replies_due[$];
  stim_row_t    dir_rows[$];
  logic [KeyW-1:0] key_pool[POOL_SIZE];

  int idle_pct;
  int stall_pct;
  int errors        = 0;
  int beats_sent;
  int beats_checked = 0;
  int full_rejects  = 0;
  int lookup_hits   = 0;
  int cycles        = 0;

  // Record one failing field, or a beat that nobody asked for.
  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h (result beat %0d, t=%0t)",
             what, got, want, beats_checked, $time);
    errors++;
  endtask

  // Apply one command to the shadow table and return the reply it must give.
  function automatic table_reply_t apply_table_cmd(input logic [CmdW-1:0] c,
                                                   input logic [KeyW-1:0] k,
                                                   input logic [PayW-1:0] p);
    table_reply_t r;
    int found;
    int wr;
    r = '0;
    r.status = ST_OK;
    found = -1;
    case (c)
      CMD_ADD: begin
        if (shadow_fill >= SlotsDef) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_fill]  = k;
          shadow_pay[shadow_fill]  = p;
          shadow_dead[shadow_fill] = 1'b0;
          shadow_fill++;
          shadow_dirty = 1'b1;
        end
      end
      CMD_GET, CMD_UPDATE, CMD_DELETE: begin
        // First live slot with the key wins; later duplicates stay hidden.
        for (int i = 0; i < shadow_fill; i++) begin
          if (found < 0 && !shadow_dead[i] && shadow_key[i] == k) found = i;
        end
        if (found < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.hit = 1'b1;
          if (c == CMD_GET) begin
            r.payload = shadow_pay[found];
          end else if (c == CMD_UPDATE) begin
            shadow_pay[found] = p;
            shadow_dirty = 1'b1;
          end else begin
            shadow_dead[found] = 1'b1;
            shadow_dirty = 1'b1;
          end
        end
      end
      CMD_COMPACT: begin
        // Squeeze out tombstones, keep survivors in order.
        wr = 0;
        for (int rd = 0; rd < shadow_fill; rd++) begin
          if (!shadow_dead[rd]) begin
            shadow_key[wr]  = shadow_key[rd];
            shadow_pay[wr]  = shadow_pay[rd];
            shadow_dead[wr] = 1'b0;
            wr++;
          end
        end
        shadow_fill  = wr;
        shadow_dirty = 1'b0;
      end
      default: begin
      end
    endcase
    r.entries = CntW'(shadow_fill);
    r.free    = CntW'(SlotsDef - shadow_fill);
    r.full    = (shadow_fill == SlotsDef);
    r.empty   = (shadow_fill == 0);
    r.dirty   = shadow_dirty;
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [CmdW-1:0] c,
                                          input logic [KeyW-1:0] k,
                                          input logic [PayW-1:0] p);
    stim_row_t s;
    s.cmd   = c;
    s.key   = k;
    s.pay   = p;
    s.typed = 1'b0;
    s.reply = '0;
    return s;
  endfunction

  // Row with its reply spelled out; occupancy flags follow from the count.
  function automatic stim_row_t typed_row(input logic [CmdW-1:0] c,
                                          input logic [KeyW-1:0] k,
                                          input logic [PayW-1:0] p,
                                          input logic [StatW-1:0] st,
                                          input logic h,
                                          input logic [PayW-1:0] po,
                                          input int entries,
                                          input logic d);
    stim_row_t s;
    s = plain_row(c, k, p);
    s.typed         = 1'b1;
    s.reply.status  = st;
    s.reply.hit     = h;
    s.reply.payload = po;
    s.reply.entries = CntW'(entries);
    s.reply.free    = CntW'(SlotsDef - entries);
    s.reply.full    = (entries == SlotsDef);
    s.reply.empty   = (entries == 0);
    s.reply.dirty   = d;
    return s;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t s);
    dir_rows.insert(dir_rows.size(), s);
  endfunction

  // Drive one request beat: idle first as the phase asks, then hold valid
  // until the block takes it. Inputs move only at the falling edge.
  task automatic send_request(input stim_row_t s);
    table_reply_t calc;
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= s.cmd;
    in_chan.record_key     <= s.key;
    in_chan.record_payload <= s.pay;
    do @(posedge clk); while (!in_chan.ready);
    calc = apply_table_cmd(s.cmd, s.key, s.pay);
    replies_due.insert(replies_due.size(), s.typed ? s.reply : calc);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [CmdW-1:0] pick_cmd(input traffic_mode_t mode);
    int r;
    int add_w;
    int get_w;
    int upd_w;
    int del_w;
    int cmp_w;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin add_w = 70; get_w = 10; upd_w = 8;  del_w = 7;  cmp_w = 2;  end
      MODE_MIXED: begin add_w = 35; get_w = 20; upd_w = 15; del_w = 20; cmp_w = 6;  end
      default:    begin add_w = 15; get_w = 20; upd_w = 10; del_w = 40; cmp_w = 12; end
    endcase
    if (r < add_w) return CMD_ADD;
    r -= add_w;
    if (r < get_w) return CMD_GET;
    r -= get_w;
    if (r < upd_w) return CMD_UPDATE;
    r -= upd_w;
    if (r < del_w) return CMD_DELETE;
    r -= del_w;
    if (r < cmp_w) return CMD_COMPACT;
    case ($urandom_range(0, 2))
      0:       return CMD_RSVD5;
      1:       return CMD_RSVD6;
      default: return CMD_RSVD7;
    endcase
  endfunction

  // Mostly pool keys so lookups hit and duplicates pile up; some wild keys.
  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Receiver side: stall at the phase's rate, decided at each falling edge.
  always @(negedge clk) begin
    out_chan.ready <= !(stall_pct > 0 && $urandom_range(1, 100) <= stall_pct);
  end

  // Check every accepted result beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    table_reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (replies_due.size() == 0) begin
        note_mismatch("unexpected result beat, status", 64'(out_chan.status), 64'd0);
      end else begin
        want = replies_due.pop_front();
        if (out_chan.status !== want.status)
          note_mismatch("status", 64'(out_chan.status), 64'(want.status));
        if (out_chan.hit !== want.hit)
          note_mismatch("hit", 64'(out_chan.hit), 64'(want.hit));
        if (out_chan.payload_out !== want.payload)
          note_mismatch("payload_out", out_chan.payload_out, want.payload);
        if (out_chan.entry_count !== want.entries)
          note_mismatch("entry_count", 64'(out_chan.entry_count), 64'(want.entries));
        if (out_chan.free_count !== want.free)
          note_mismatch("free_count", 64'(out_chan.free_count), 64'(want.free));
        if (out_chan.is_full !== want.full)
          note_mismatch("is_full", 64'(out_chan.is_full), 64'(want.full));
        if (out_chan.is_empty !== want.empty)
          note_mismatch("is_empty", 64'(out_chan.is_empty), 64'(want.empty));
        if (out_chan.is_dirty !== want.dirty)
          note_mismatch("is_dirty", 64'(out_chan.is_dirty), 64'(want.dirty));
        if (want.status == ST_FULL) full_rejects++;
        if (want.hit) lookup_hits++;
      end
      beats_checked++;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, replies_due.size());
      $display("FAIL record_slot_table_with_tombstones_top");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t     s;
    traffic_mode_t mode;
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_ADD;
    in_chan.record_key     = '0;
    in_chan.record_payload = '0;
    idle_pct               = 0;
    stall_pct              = 0;
    beats_sent             = 0;
    shadow_fill            = 0;
    shadow_dirty           = 1'b0;

    // Keep the extreme keys in the pool, fill the rest at random.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed part: empty table, reserved codes, duplicates, tombstones.
    // Lookups on the empty table miss and leave the dirty flag clear.
    add_row(typed_row(CMD_GET,     '0, '0, ST_MISSING, 1'b0, '0, 0, 1'b0));
    add_row(typed_row(CMD_UPDATE,  '1, '1, ST_MISSING, 1'b0, '0, 0, 1'b0));
    add_row(typed_row(CMD_DELETE,  '0, '0, ST_MISSING, 1'b0, '0, 0, 1'b0));
    add_row(typed_row(CMD_COMPACT, '0, '0, ST_OK,      1'b0, '0, 0, 1'b0));
    add_row(typed_row(CMD_RSVD5,   '1, '1, ST_OK,      1'b0, '0, 0, 1'b0));
    // First records, all-ones and all-zeros fields.
    add_row(typed_row(CMD_ADD,     '1, '1, ST_OK,      1'b0, '0, 1, 1'b1));
    add_row(typed_row(CMD_GET,     '1, '0, ST_OK,      1'b1, '1, 1, 1'b1));
    add_row(typed_row(CMD_ADD,     '0, '0, ST_OK,      1'b0, '0, 2, 1'b1));
    // Duplicate key: hidden until the first copy is deleted.
    add_row(typed_row(CMD_ADD, '1, 64'h5555_5555_5555_5555,
                      ST_OK, 1'b0, '0, 3, 1'b1));
    add_row(plain_row(CMD_GET,    '1, '0));
    add_row(plain_row(CMD_DELETE, '1, '0));
    add_row(plain_row(CMD_GET,    '1, '0));
    add_row(plain_row(CMD_UPDATE, '0, 64'hAAAA_AAAA_AAAA_AAAA));
    add_row(plain_row(CMD_GET,    '0, '1));
    add_row(plain_row(CMD_RSVD7,  '0, '0));
    add_row(plain_row(CMD_GET,    32'h1234_5678, '0));
    add_row(plain_row(CMD_COMPACT, '1, '1));
    add_row(plain_row(CMD_RSVD6,  '1, '1));
    add_row(plain_row(CMD_DELETE, '1, '0));
    add_row(plain_row(CMD_DELETE, '0, '0));
    add_row(plain_row(CMD_GET,    '0, '0));
    // Everything is a tombstone now, so compaction empties the table.
    add_row(typed_row(CMD_COMPACT, '0, '0, ST_OK, 1'b0, '0, 0, 1'b0));
    add_row(plain_row(CMD_ADD, 32'h8000_0000, 64'h8000_0000_0000_0001));

    // Hold reset, then release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // Random part in four handshake phases: free running, slow sender,
    // slow receiver, both sides idling now and then. Traffic cycles through
    // fill, mixed and drain shapes so the table reaches full and empties again.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 81; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        case ((n / 60) % 3)
          0:       mode = MODE_FILL;
          1:       mode = MODE_MIXED;
          default: mode = MODE_DRAIN;
        endcase
        s = plain_row(pick_cmd(mode), pick_key(), {$urandom, $urandom});
        send_request(s);
      end
    end
    in_chan.valid <= 1'b0;

    // Drain: wait for every outstanding reply, then watch for strays.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SlotsDef + 8) @(posedge clk);

    $display("sent %0d requests and checked %0d replies over %0d cycles",
             beats_sent, beats_checked, cycles);
    $display("full rejections %0d, lookup hits %0d, mismatches %0d",
             full_rejects, lookup_hits, errors);
    if (errors == 0) begin
      $display("PASS record_slot_table_with_tombstones_top");
    end else begin
      $display("FAIL record_slot_table_with_tombstones_top");
    end
    $finish;
  end

endmodule
